// ===== rtl/lob_pkg.sv =====
// Shared codes, field widths and control types of the order book engine.
`default_nettype none
package lob_pkg;

  // Message kinds carried on the input tuser.
  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_CANCEL  = 3'd1;
  localparam logic [2:0] REQ_DELETE  = 3'd2;
  localparam logic [2:0] REQ_REPLACE = 3'd3;
  localparam logic [2:0] REQ_EXEC    = 3'd4;

  // Result status carried on the output tuser.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_DUP     = 2'd3;

  localparam int KEY_W     = 64;
  localparam int QTY_W     = 32;
  localparam int TOT_W     = 48;
  localparam int PRICE_W   = 12;
  localparam int ORD_W     = 13;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int IN_DATA_W = 176;
  localparam int OUT_DATA_W = 176;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Command to the level total unit.
  typedef struct packed {
    logic             sub;
    logic [QTY_W-1:0] amount;
  } alu_req_t;

endpackage
`default_nettype wire

// ===== rtl/lob_count_alu.sv =====
// Saturating add and floor-at-zero subtract of a level's total quantity.
`default_nettype none
module lob_count_alu (
  input  wire logic [lob_pkg::TOT_W-1:0] tot_in,
  input  wire lob_pkg::alu_req_t         req,
  output logic      [lob_pkg::TOT_W-1:0] tot_out
);

  logic [lob_pkg::TOT_W:0]   sum;
  logic [lob_pkg::TOT_W-1:0] amt;

  always_comb begin
    amt = lob_pkg::TOT_W'(req.amount);
    sum = {1'b0, tot_in} + {1'b0, amt};
    if (req.sub) begin
      tot_out = (amt > tot_in) ? '0 : tot_in - amt;
    end else begin
      tot_out = sum[lob_pkg::TOT_W] ? lob_pkg::TOT_MAX : sum[lob_pkg::TOT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/l3_order_book_engine_core.sv =====
// Top level of the level-3 order book engine: sequencer, slot, level and free-list memories.
`default_nettype none
// The engine keeps a table of resting orders and a doubly linked first-in first-out
// queue for each side and price level, and applies one feed request at a time. An
// order id is found by sweeping the whole slot memory, one slot per cycle, which sets
// the pace. After the sweep a request that ends in an error goes straight to its
// result, while the others read, modify and write the slot and level memories step by
// step; a result that the receiver stalls holds the sequencer until it can be
// registered. A request is taken only while the sequencer is idle; finished results
// wait in an output register, so the next request may start while a result is still
// waiting. After reset a clearing pass zeroes the level memory, invalidates every
// slot and refills the free list; no request is taken during it. Request kinds 5 to
// 7 are consumed in the idle state and give no result.
module l3_order_book_engine_core #(
  parameter int ORDER_CAPACITY = 4096,
  parameter int PRICE_LEVELS   = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [63:0] order_key, [127:64] new_order_key, [139:128] price_tick,
  // [171:140] quantity, [172] is_ask, [175:173] zero
  input  wire logic [lob_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] req_type
  input  wire logic [lob_pkg::REQ_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] level_is_ask, [12:1] level_price, [25:13] level_orders,
  // [73:26] level_total, [137:74] front_order_key, [169:138] front_quantity,
  // [175:170] zero
  output logic      [lob_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic      [lob_pkg::STAT_W-1:0]      out_tuser,
  output logic                                 out_tlast
);

  localparam int SW       = $clog2(ORDER_CAPACITY);
  localparam int CW       = $clog2(ORDER_CAPACITY + 1);
  localparam int PW       = $clog2(PRICE_LEVELS);
  localparam int LW       = PW + 1;
  localparam int LD       = 2 ** LW;
  localparam int CLR_N    = (ORDER_CAPACITY > LD) ? ORDER_CAPACITY : LD;
  localparam int CLRW     = $clog2(CLR_N);

  localparam logic [SW:0] NIL = (SW+1)'(ORDER_CAPACITY);

  localparam logic [4:0] ST_CLR      = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_SCAN     = 5'd2;
  localparam logic [4:0] ST_SCAN_END = 5'd3;
  localparam logic [4:0] ST_DISP     = 5'd4;
  localparam logic [4:0] ST_ERR      = 5'd5;
  localparam logic [4:0] ST_ADD_FREE = 5'd6;
  localparam logic [4:0] ST_GOT_S    = 5'd7;
  localparam logic [4:0] ST_GOT_L    = 5'd8;
  localparam logic [4:0] ST_WB_PART  = 5'd9;
  localparam logic [4:0] ST_UL_P     = 5'd10;
  localparam logic [4:0] ST_UL_P2    = 5'd11;
  localparam logic [4:0] ST_UL_N     = 5'd12;
  localparam logic [4:0] ST_UL_N2    = 5'd13;
  localparam logic [4:0] ST_UL_DONE  = 5'd14;
  localparam logic [4:0] ST_LK_RD    = 5'd15;
  localparam logic [4:0] ST_LK_L     = 5'd16;
  localparam logic [4:0] ST_LK_T     = 5'd17;
  localparam logic [4:0] ST_LK_WB    = 5'd18;
  localparam logic [4:0] ST_EMIT     = 5'd19;
  localparam logic [4:0] ST_EM_L     = 5'd20;
  localparam logic [4:0] ST_EM_H     = 5'd21;

  typedef struct packed {
    logic                        valid;
    logic [lob_pkg::KEY_W-1:0]   key;
    logic [LW-1:0]               lv;
    logic [lob_pkg::QTY_W-1:0]   rem;
    logic [SW:0]                 prev;
    logic [SW:0]                 next;
  } slot_t;

  typedef struct packed {
    logic [CW-1:0]               cnt;
    logic [lob_pkg::TOT_W-1:0]   tot;
    logic [SW:0]                 head;
    logic [SW:0]                 tail;
  } lvl_t;

  // Memories.
  slot_t       smem [ORDER_CAPACITY];
  lvl_t        lmem [LD];
  logic [SW-1:0] fmem [ORDER_CAPACITY];

  logic          sm_re, sm_we;
  logic [SW-1:0] sm_raddr, sm_waddr;
  slot_t         sm_wdata, sm_rdata;
  logic          lm_re, lm_we;
  logic [LW-1:0] lm_raddr, lm_waddr;
  lvl_t          lm_wdata, lm_rdata;
  logic          fm_re, fm_we;
  logic [SW-1:0] fm_raddr, fm_waddr, fm_wdata, fm_rdata;

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_waddr] <= sm_wdata;
    if (sm_re) sm_rdata <= smem[sm_raddr];
    if (lm_we) lmem[lm_waddr] <= lm_wdata;
    if (lm_re) lm_rdata <= lmem[lm_raddr];
    if (fm_we) fmem[fm_waddr] <= fm_wdata;
    if (fm_re) fm_rdata <= fmem[fm_raddr];
  end

  // Control registers.
  logic [4:0]    state_r, state_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic          chk_r, chk_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          second_r, second_nxt;
  logic          ov_r, ov_nxt;

  // Payload registers.
  logic [SW-1:0] chk_idx_r, chk_idx_nxt;
  logic          sfound_r, sfound_nxt, ofound_r, ofound_nxt;
  logic [SW-1:0] s_r, s_nxt, o_r, o_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [lob_pkg::KEY_W-1:0] key_r, key_nxt, nkey_r, nkey_nxt;
  logic [lob_pkg::QTY_W-1:0] qty_r, qty_nxt;
  logic          side_r, side_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  slot_t         srec_r, srec_nxt;
  lvl_t          lrec_r, lrec_nxt;
  logic [LW-1:0] lv_r, lv_nxt, oldlv_r, oldlv_nxt;
  logic [lob_pkg::STAT_W-1:0] estat_r, estat_nxt;
  logic [lob_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic [lob_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic          olast_r, olast_nxt;

  // Level total unit, shared by the subtract after lookup and the add on linking.
  lob_pkg::alu_req_t alu_req;
  logic [lob_pkg::TOT_W-1:0] alu_tot;
  logic [lob_pkg::QTY_W-1:0] take;
  logic [lob_pkg::QTY_W-1:0] rem_left;

  always_comb begin
    if (qty_r < srec_r.rem && (op_r == lob_pkg::REQ_CANCEL || op_r == lob_pkg::REQ_EXEC)) begin
      take = qty_r;
    end else begin
      take = srec_r.rem;
    end
    rem_left       = srec_r.rem - take;
    alu_req.sub    = (state_r == ST_GOT_L);
    alu_req.amount = alu_req.sub ? take : srec_r.rem;
  end

  lob_count_alu u_alu (
    .tot_in  (lm_rdata.tot),
    .req     (alu_req),
    .tot_out (alu_tot)
  );

  logic          out_can;
  logic [LW-1:0] nlv, emlv;
  logic          em_first;

  assign out_can  = !ov_r || out_tready;
  assign em_first = (op_r == lob_pkg::REQ_REPLACE) && !second_r;
  assign nlv      = {((op_r == lob_pkg::REQ_ADD) ? side_r : oldlv_r[LW-1]), pc_r};
  assign emlv     = em_first ? oldlv_r : lv_r;

  always_comb begin
    slot_t         ts;
    lvl_t          tl;
    logic [31:0]   price32;
    logic [CW-1:0] fdec;
    logic [lob_pkg::KEY_W-1:0] fkey;
    logic [lob_pkg::QTY_W-1:0] fqty;

    state_nxt   = state_r;
    clr_nxt     = clr_r;
    scan_nxt    = scan_r;
    chk_nxt     = 1'b0;
    fcnt_nxt    = fcnt_r;
    second_nxt  = second_r;
    ov_nxt      = out_tready ? 1'b0 : ov_r;
    chk_idx_nxt = chk_idx_r;
    sfound_nxt  = sfound_r;
    ofound_nxt  = ofound_r;
    s_nxt       = s_r;
    o_nxt       = o_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    nkey_nxt    = nkey_r;
    qty_nxt     = qty_r;
    side_nxt    = side_r;
    pc_nxt      = pc_r;
    srec_nxt    = srec_r;
    lrec_nxt    = lrec_r;
    lv_nxt      = lv_r;
    oldlv_nxt   = oldlv_r;
    estat_nxt   = estat_r;
    ostat_nxt   = ostat_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;

    sm_re = 1'b0; sm_raddr = '0; sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0;
    lm_re = 1'b0; lm_raddr = '0; lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0;
    fm_re = 1'b0; fm_raddr = '0; fm_we = 1'b0; fm_waddr = '0; fm_wdata = '0;

    ts      = sm_rdata;
    tl      = lm_rdata;
    price32 = {20'd0, in_tdata[139:128]};
    fdec    = fcnt_r - 1'b1;
    fkey    = '0;
    fqty    = '0;

    // The sweep compares the slot read in the previous cycle.
    if (chk_r) begin
      if (sm_rdata.valid && sm_rdata.key == key_r) begin
        sfound_nxt = 1'b1;
        s_nxt      = chk_idx_r;
      end
      if (sm_rdata.valid && sm_rdata.key == nkey_r) begin
        ofound_nxt = 1'b1;
        o_nxt      = chk_idx_r;
      end
    end

    unique case (state_r)
      ST_CLR: begin
        if (32'(clr_r) < 32'(ORDER_CAPACITY)) begin
          sm_we    = 1'b1;
          sm_waddr = clr_r[SW-1:0];
          fm_we    = 1'b1;
          fm_waddr = clr_r[SW-1:0];
          fm_wdata = clr_r[SW-1:0];
        end
        if (32'(clr_r) < 32'(LD)) begin
          lm_we    = 1'b1;
          lm_waddr = clr_r[LW-1:0];
        end
        if (32'(clr_r) == 32'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          key_nxt    = in_tdata[63:0];
          nkey_nxt   = in_tdata[127:64];
          qty_nxt    = in_tdata[171:140];
          side_nxt   = in_tdata[172];
          pc_nxt     = (price32 >= 32'(PRICE_LEVELS)) ? PW'(PRICE_LEVELS - 1)
                                                      : PW'(in_tdata[139:128]);
          sfound_nxt = 1'b0;
          ofound_nxt = 1'b0;
          second_nxt = 1'b0;
          scan_nxt   = '0;
          if (in_tuser <= lob_pkg::REQ_EXEC) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        sm_re       = 1'b1;
        sm_raddr    = scan_r;
        chk_nxt     = 1'b1;
        chk_idx_nxt = scan_r;
        if (scan_r == SW'(ORDER_CAPACITY - 1)) begin
          state_nxt = ST_SCAN_END;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (op_r == lob_pkg::REQ_ADD) begin
          if (sfound_r) begin
            estat_nxt = lob_pkg::STAT_DUP;
            state_nxt = ST_ERR;
          end else if (fcnt_r == '0) begin
            estat_nxt = lob_pkg::STAT_FULL;
            state_nxt = ST_ERR;
          end else begin
            fm_re     = 1'b1;
            fm_raddr  = fdec[SW-1:0];
            fcnt_nxt  = fdec;
            state_nxt = ST_ADD_FREE;
          end
        end else if (!sfound_r) begin
          estat_nxt = lob_pkg::STAT_UNKNOWN;
          state_nxt = ST_ERR;
        end else if (op_r == lob_pkg::REQ_REPLACE && ofound_r && o_r != s_r) begin
          estat_nxt = lob_pkg::STAT_DUP;
          state_nxt = ST_ERR;
        end else begin
          sm_re     = 1'b1;
          sm_raddr  = s_r;
          state_nxt = ST_GOT_S;
        end
      end
      ST_ERR: begin
        if (out_can) begin
          ov_nxt    = 1'b1;
          ostat_nxt = estat_r;
          odata_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_FREE: begin
        s_nxt          = fm_rdata;
        srec_nxt.valid = 1'b1;
        srec_nxt.key   = key_r;
        srec_nxt.lv    = nlv;
        srec_nxt.rem   = qty_r;
        lv_nxt         = nlv;
        state_nxt      = ST_LK_RD;
      end
      ST_GOT_S: begin
        srec_nxt  = sm_rdata;
        lv_nxt    = sm_rdata.lv;
        oldlv_nxt = sm_rdata.lv;
        lm_re     = 1'b1;
        lm_raddr  = sm_rdata.lv;
        state_nxt = ST_GOT_L;
      end
      ST_GOT_L: begin
        tl.tot   = alu_tot;
        lrec_nxt = tl;
        if (op_r == lob_pkg::REQ_CANCEL || op_r == lob_pkg::REQ_EXEC) begin
          srec_nxt.rem = rem_left;
          state_nxt    = (rem_left != '0) ? ST_WB_PART : ST_UL_P;
        end else begin
          state_nxt = ST_UL_P;
        end
      end
      ST_WB_PART: begin
        sm_we     = 1'b1;
        sm_waddr  = s_r;
        sm_wdata  = srec_r;
        lm_we     = 1'b1;
        lm_waddr  = lv_r;
        lm_wdata  = lrec_r;
        state_nxt = ST_EMIT;
      end
      ST_UL_P: begin
        if (srec_r.prev == NIL) begin
          lrec_nxt.head = srec_r.next;
          state_nxt     = ST_UL_N;
        end else begin
          sm_re     = 1'b1;
          sm_raddr  = srec_r.prev[SW-1:0];
          state_nxt = ST_UL_P2;
        end
      end
      ST_UL_P2: begin
        ts.next   = srec_r.next;
        sm_we     = 1'b1;
        sm_waddr  = srec_r.prev[SW-1:0];
        sm_wdata  = ts;
        state_nxt = ST_UL_N;
      end
      ST_UL_N: begin
        if (srec_r.next == NIL) begin
          lrec_nxt.tail = srec_r.prev;
          state_nxt     = ST_UL_DONE;
        end else begin
          sm_re     = 1'b1;
          sm_raddr  = srec_r.next[SW-1:0];
          state_nxt = ST_UL_N2;
        end
      end
      ST_UL_N2: begin
        ts.prev   = srec_r.prev;
        sm_we     = 1'b1;
        sm_waddr  = srec_r.next[SW-1:0];
        sm_wdata  = ts;
        state_nxt = ST_UL_DONE;
      end
      ST_UL_DONE: begin
        tl = lrec_r;
        if (tl.cnt != '0) begin
          tl.cnt = tl.cnt - 1'b1;
        end
        lrec_nxt = tl;
        lm_we    = 1'b1;
        lm_waddr = lv_r;
        lm_wdata = tl;
        if (op_r == lob_pkg::REQ_REPLACE) begin
          srec_nxt.key = nkey_r;
          srec_nxt.lv  = nlv;
          srec_nxt.rem = qty_r;
          lv_nxt       = nlv;
          state_nxt    = ST_LK_RD;
        end else begin
          ts        = srec_r;
          ts.valid  = 1'b0;
          sm_we     = 1'b1;
          sm_waddr  = s_r;
          sm_wdata  = ts;
          if (fcnt_r < CW'(ORDER_CAPACITY)) begin
            fm_we    = 1'b1;
            fm_waddr = fcnt_r[SW-1:0];
            fm_wdata = s_r;
            fcnt_nxt = fcnt_r + 1'b1;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_LK_RD: begin
        lm_re     = 1'b1;
        lm_raddr  = lv_r;
        state_nxt = ST_LK_L;
      end
      ST_LK_L: begin
        srec_nxt.prev = NIL;
        srec_nxt.next = NIL;
        if (lm_rdata.cnt == '0) begin
          tl.head   = {1'b0, s_r};
          state_nxt = ST_LK_WB;
        end else begin
          srec_nxt.prev = lm_rdata.tail;
          sm_re         = 1'b1;
          sm_raddr      = lm_rdata.tail[SW-1:0];
          state_nxt     = ST_LK_T;
        end
        tl.tail  = {1'b0, s_r};
        tl.cnt   = lm_rdata.cnt + 1'b1;
        tl.tot   = alu_tot;
        lrec_nxt = tl;
      end
      ST_LK_T: begin
        ts.next   = {1'b0, s_r};
        sm_we     = 1'b1;
        sm_waddr  = srec_r.prev[SW-1:0];
        sm_wdata  = ts;
        state_nxt = ST_LK_WB;
      end
      ST_LK_WB: begin
        sm_we     = 1'b1;
        sm_waddr  = s_r;
        sm_wdata  = srec_r;
        lm_we     = 1'b1;
        lm_waddr  = lv_r;
        lm_wdata  = lrec_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        lm_re     = 1'b1;
        lm_raddr  = emlv;
        state_nxt = ST_EM_L;
      end
      ST_EM_L: begin
        lrec_nxt  = lm_rdata;
        sm_re     = 1'b1;
        sm_raddr  = lm_rdata.head[SW-1:0];
        state_nxt = ST_EM_H;
      end
      ST_EM_H: begin
        if (out_can) begin
          if (lrec_r.cnt != '0) begin
            fkey = sm_rdata.key;
            fqty = sm_rdata.rem;
          end
          ov_nxt    = 1'b1;
          ostat_nxt = lob_pkg::STAT_OK;
          odata_nxt = {6'd0, fqty, fkey, lrec_r.tot, lob_pkg::ORD_W'(lrec_r.cnt),
                       lob_pkg::PRICE_W'(emlv[PW-1:0]), emlv[LW-1]};
          olast_nxt = !em_first;
          if (em_first) begin
            second_nxt = 1'b1;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      scan_r   <= '0;
      chk_r    <= 1'b0;
      fcnt_r   <= CW'(ORDER_CAPACITY);
      second_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      scan_r   <= scan_nxt;
      chk_r    <= chk_nxt;
      fcnt_r   <= fcnt_nxt;
      second_r <= second_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    sfound_r  <= sfound_nxt;
    ofound_r  <= ofound_nxt;
    s_r       <= s_nxt;
    o_r       <= o_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    nkey_r    <= nkey_nxt;
    qty_r     <= qty_nxt;
    side_r    <= side_nxt;
    pc_r      <= pc_nxt;
    srec_r    <= srec_nxt;
    lrec_r    <= lrec_nxt;
    lv_r      <= lv_nxt;
    oldlv_r   <= oldlv_nxt;
    estat_r   <= estat_nxt;
    ostat_r   <= ostat_nxt;
    odata_r   <= odata_nxt;
    olast_r   <= olast_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

  // The sequencer never reads an entry in the same cycle that it writes it.
  a_slot_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(sm_we && sm_re && sm_waddr == sm_raddr))
    else $error("slot memory read and write collide");

  a_level_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(lm_we && lm_re && lm_waddr == lm_raddr))
    else $error("level memory read and write collide");

  // The free list never holds more slots than the table has.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= CW'(ORDER_CAPACITY))
    else $error("free slot count above capacity");

  // Only the old-level report of a successful replace is not the last result.
  a_first_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == lob_pkg::STAT_OK)
    else $error("non-final result carries an error status");

endmodule
`default_nettype wire
